>>> rtl/dfs_maze_generator_macros.svh
`ifndef DFS_MAZE_GENERATOR_MACROS_SVH
`define DFS_MAZE_GENERATOR_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define DMG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DMG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dmg_pkg.sv
package dmg_pkg;

  localparam int GRID_X   = 32;
  localparam int GRID_Z   = 32;
  localparam int X_W      = $clog2(GRID_X);
  localparam int Z_W      = $clog2(GRID_Z);
  localparam int CELL_W   = X_W + Z_W;
  localparam int CELLS    = GRID_X * GRID_Z;
  localparam int CNT_W    = 11;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int LINK_W   = 4;
  localparam int ENTRY_W  = LINK_W + 1;  // links plus on-path mark
  localparam int TRY_W    = 3;
  localparam int TRIES    = 5;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_START_X     = 2'd2,
    CFG_START_Z     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_S = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    KIND_ADVANCE   = 2'd0,
    KIND_BACKTRACK = 2'd1,
    KIND_IDLE      = 2'd2,
    KIND_RESTART   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_RESTART,
    DP_CLEAR,
    DP_RMARK,
    DP_START,
    DP_LATCH,
    DP_MARK_DONE,
    DP_NB_READ,
    DP_NEXT_DIR,
    DP_CARVE1,
    DP_CARVE2,
    DP_POP_RD,
    DP_POP_LOAD,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    kind_t  kind;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic count_reached;
    logic done;
    logic dir_ok;
    logic nb_free;
    logic try_last;
    logic stack_empty;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/dmg_ram.sv
module dmg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/dmg_ctrl.sv
`include "dfs_maze_generator_macros.svh"

module dmg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_mode,
  output logic                in_tready,
  input  dmg_pkg::dp_status_t status,
  output dmg_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_RMARK,
    S_IDLE,
    S_LATCH,
    S_MDONE,
    S_TRY,
    S_TEST,
    S_CARVE1,
    S_CARVE2,
    S_NOWAY,
    S_POP,
    S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  dmg_pkg::kind_t  kind_r, kind_nxt;
  logic            restart_r, restart_nxt;

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    restart_nxt = restart_r;
    cmd.op      = dmg_pkg::DP_NONE;
    cmd.kind    = kind_r;
    in_tready   = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = dmg_pkg::DP_CLEAR;
        if (status.clr_last) begin
          state_nxt = restart_r ? S_RMARK : S_IDLE;
        end
      end
      S_RMARK: begin
        cmd.op    = dmg_pkg::DP_RMARK;
        kind_nxt  = dmg_pkg::KIND_RESTART;
        state_nxt = S_EMIT;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_mode) begin
            cmd.op      = dmg_pkg::DP_RESTART;
            restart_nxt = 1'b1;
            state_nxt   = S_CLEAR;
          end else begin
            cmd.op = dmg_pkg::DP_START;
            if (status.done) begin
              kind_nxt  = dmg_pkg::KIND_IDLE;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_LATCH;
            end
          end
        end
      end
      S_LATCH: begin
        cmd.op    = dmg_pkg::DP_LATCH;
        state_nxt = status.count_reached ? S_MDONE : S_TRY;
      end
      S_MDONE: begin
        cmd.op    = dmg_pkg::DP_MARK_DONE;
        kind_nxt  = dmg_pkg::KIND_IDLE;
        state_nxt = S_EMIT;
      end
      S_TRY: begin
        priority if (status.dir_ok) begin
          cmd.op    = dmg_pkg::DP_NB_READ;
          state_nxt = S_TEST;
        end else if (status.try_last) begin
          state_nxt = S_NOWAY;
        end else begin
          cmd.op = dmg_pkg::DP_NEXT_DIR;
        end
      end
      S_TEST: begin
        priority if (status.nb_free) begin
          state_nxt = S_CARVE1;
        end else if (status.try_last) begin
          state_nxt = S_NOWAY;
        end else begin
          cmd.op    = dmg_pkg::DP_NEXT_DIR;
          state_nxt = S_TRY;
        end
      end
      S_CARVE1: begin
        cmd.op    = dmg_pkg::DP_CARVE1;
        state_nxt = S_CARVE2;
      end
      S_CARVE2: begin
        cmd.op    = dmg_pkg::DP_CARVE2;
        kind_nxt  = dmg_pkg::KIND_ADVANCE;
        state_nxt = S_EMIT;
      end
      S_NOWAY: begin
        if (status.stack_empty) begin
          kind_nxt  = dmg_pkg::KIND_IDLE;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = dmg_pkg::DP_POP_RD;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        cmd.op    = dmg_pkg::DP_POP_LOAD;
        kind_nxt  = dmg_pkg::KIND_BACKTRACK;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op    = dmg_pkg::DP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      kind_r    <= dmg_pkg::KIND_IDLE;
      restart_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      kind_r    <= kind_nxt;
      restart_r <= restart_nxt;
    end
  end

  `DMG_ASSERT_NEXT(a_accept_leaves_idle, in_tvalid && in_tready, !in_tready,
                   "ready stayed high after a request was taken")
  `DMG_ASSERT_NOW(a_emit_has_room, cmd.op == dmg_pkg::DP_EMIT, status.out_free,
                  "result loaded while output register is occupied")

endmodule

>>> rtl/dmg_datapath.sv
`include "dfs_maze_generator_macros.svh"

module dmg_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dmg_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [dmg_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [1:0]                         in_random_dir,
  input  dmg_pkg::dp_cmd_t                   cmd,
  output dmg_pkg::dp_status_t                status,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [1:0]                         out_tuser,
  output logic [dmg_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int XW = dmg_pkg::X_W;
  localparam int ZW = dmg_pkg::Z_W;
  localparam int CW = dmg_pkg::CELL_W;
  localparam int NW = dmg_pkg::CNT_W;
  localparam int FW = dmg_pkg::CFG_W;
  localparam int LW = dmg_pkg::LINK_W;

  logic [FW-1:0] grid_width_r, grid_height_r;
  logic [XW-1:0] start_x_r;
  logic [ZW-1:0] start_z_r;

  logic [CW-1:0] clr_r;
  logic [NW-1:0] stack_depth_r;
  logic [CW-1:0] current_r;
  logic [NW-1:0] visited_r;
  logic [CW-1:0] end_r;
  logic          done_r;

  dmg_pkg::dir_t              dir_r;
  logic [dmg_pkg::TRY_W-1:0]  try_r;
  logic [LW-1:0]              cur_links_r;
  logic [CW-1:0]              nidx_r;

  logic          out_valid_r;
  dmg_pkg::kind_t out_kind_r;
  logic [CW-1:0] out_cell_r;
  dmg_pkg::dir_t out_dir_r;
  logic          out_fin_r;
  logic [CW-1:0] out_end_r;

  logic [FW-1:0]   eff_w, eff_h;
  logic [2*FW-1:0] area;
  logic [NW-1:0]   total;
  logic [XW-1:0]   cx, sx;
  logic [ZW-1:0]   cz, sz;
  logic [FW-1:0]   cx6, cz6;
  logic            dir_ok;
  logic [CW-1:0]   nidx;
  logic [NW-1:0]   visited_inc, depth_dec;
  logic            done_new;
  dmg_pkg::dir_t   opp_dir;

  logic                         lk_we, lk_re;
  logic [CW-1:0]                lk_waddr, lk_raddr;
  logic [dmg_pkg::ENTRY_W-1:0]  lk_wdata, lk_rdata;
  logic                         sk_we, sk_re;
  logic [CW-1:0]                sk_waddr, sk_raddr, sk_wdata, sk_rdata;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= FW'(8);
      grid_height_r <= FW'(8);
      start_x_r     <= '0;
      start_z_r     <= '0;
    end else if (cfg_we) begin
      unique case (dmg_pkg::cfg_idx_t'(cfg_addr))
        dmg_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        dmg_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        dmg_pkg::CFG_START_X:     start_x_r     <= cfg_wdata[XW-1:0];
        dmg_pkg::CFG_START_Z:     start_z_r     <= cfg_wdata[ZW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_width_r == '0) begin
      eff_w = FW'(1);
    end else if (grid_width_r > FW'(dmg_pkg::GRID_X)) begin
      eff_w = FW'(dmg_pkg::GRID_X);
    end else begin
      eff_w = grid_width_r;
    end
    if (grid_height_r == '0) begin
      eff_h = FW'(1);
    end else if (grid_height_r > FW'(dmg_pkg::GRID_Z)) begin
      eff_h = FW'(dmg_pkg::GRID_Z);
    end else begin
      eff_h = grid_height_r;
    end
  end

  assign area  = {{FW{1'b0}}, eff_w} * {{FW{1'b0}}, eff_h};
  assign total = area[NW-1:0];

  assign sx = ({1'b0, start_x_r} < eff_w) ? start_x_r : XW'(eff_w - FW'(1));
  assign sz = ({1'b0, start_z_r} < eff_h) ? start_z_r : ZW'(eff_h - FW'(1));

  assign cx  = current_r[XW-1:0];
  assign cz  = current_r[CW-1:XW];
  assign cx6 = FW'(cx);
  assign cz6 = FW'(cz);

  // neighbor bounds test against the current grid size
  always_comb begin
    dir_ok = 1'b0;
    nidx   = current_r;
    unique case (dir_r)
      dmg_pkg::DIR_N: begin
        dir_ok = (cz != '0) && ((cz6 - FW'(1)) < eff_h) && (cx6 < eff_w);
        nidx   = {ZW'(cz - ZW'(1)), cx};
      end
      dmg_pkg::DIR_E: begin
        dir_ok = ((cx6 + FW'(1)) < eff_w) && (cz6 < eff_h);
        nidx   = {cz, XW'(cx + XW'(1))};
      end
      dmg_pkg::DIR_S: begin
        dir_ok = ((cz6 + FW'(1)) < eff_h) && (cx6 < eff_w);
        nidx   = {ZW'(cz + ZW'(1)), cx};
      end
      dmg_pkg::DIR_W: begin
        dir_ok = (cx != '0) && ((cx6 - FW'(1)) < eff_w) && (cz6 < eff_h);
        nidx   = {cz, XW'(cx - XW'(1))};
      end
      default: ;
    endcase
  end

  assign visited_inc = (visited_r != '1) ? visited_r + NW'(1) : visited_r;
  assign done_new    = visited_inc >= total;
  assign depth_dec   = stack_depth_r - NW'(1);
  assign opp_dir     = dmg_pkg::dir_t'(2'(dir_r + 2'd2));

  always_comb begin
    status.clr_last      = (clr_r == '1);
    status.count_reached = (visited_r >= total);
    status.done          = done_r;
    status.dir_ok        = dir_ok;
    status.nb_free       = (lk_rdata[LW-1:0] == '0);
    status.try_last      = (try_r == dmg_pkg::TRY_W'(dmg_pkg::TRIES - 1));
    status.stack_empty   = (stack_depth_r == '0);
    status.out_free      = !out_valid_r || out_tready;
  end

  // memory port steering
  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = current_r;
    lk_wdata = '0;
    lk_re    = 1'b0;
    lk_raddr = current_r;
    sk_we    = 1'b0;
    sk_waddr = stack_depth_r[CW-1:0];
    sk_wdata = current_r;
    sk_re    = 1'b0;
    sk_raddr = depth_dec[CW-1:0];
    unique case (cmd.op)
      dmg_pkg::DP_CLEAR: begin
        lk_we    = 1'b1;
        lk_waddr = clr_r;
      end
      dmg_pkg::DP_RMARK: begin
        lk_we    = 1'b1;
        lk_wdata = {done_r, {LW{1'b0}}};
      end
      dmg_pkg::DP_START: begin
        lk_re = 1'b1;
      end
      dmg_pkg::DP_NB_READ: begin
        lk_re    = 1'b1;
        lk_raddr = nidx;
      end
      dmg_pkg::DP_MARK_DONE: begin
        lk_we    = 1'b1;
        lk_wdata = {1'b1, cur_links_r};
      end
      dmg_pkg::DP_CARVE1: begin
        lk_we    = 1'b1;
        lk_wdata = {1'b1, cur_links_r | (LW'(1) << dir_r)};
        sk_we    = (stack_depth_r < NW'(dmg_pkg::CELLS));
      end
      dmg_pkg::DP_CARVE2: begin
        lk_we    = 1'b1;
        lk_waddr = nidx_r;
        lk_wdata = {done_new, LW'(1) << opp_dir};
      end
      dmg_pkg::DP_POP_RD: begin
        lk_we    = 1'b1;
        lk_wdata = {1'b0, cur_links_r};
        sk_re    = 1'b1;
      end
      default: ;
    endcase
  end

  dmg_ram #(
    .WIDTH (dmg_pkg::ENTRY_W),
    .DEPTH (dmg_pkg::CELLS)
  ) u_links (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  dmg_ram #(
    .WIDTH (CW),
    .DEPTH (dmg_pkg::CELLS)
  ) u_stack (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .re    (sk_re),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r         <= '0;
      stack_depth_r <= '0;
      current_r     <= '0;
      visited_r     <= NW'(1);
      end_r         <= '0;
      done_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.op == dmg_pkg::DP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        dmg_pkg::DP_RESTART: begin
          clr_r         <= '0;
          current_r     <= {sz, sx};
          stack_depth_r <= '0;
          visited_r     <= NW'(1);
          done_r        <= (total == NW'(1));
          end_r         <= (total == NW'(1)) ? {sz, sx} : '0;
        end
        dmg_pkg::DP_CLEAR: begin
          clr_r <= clr_r + CW'(1);
        end
        dmg_pkg::DP_MARK_DONE: begin
          done_r <= 1'b1;
          end_r  <= current_r;
        end
        dmg_pkg::DP_CARVE1: begin
          if (stack_depth_r < NW'(dmg_pkg::CELLS)) begin
            stack_depth_r <= stack_depth_r + NW'(1);
          end
        end
        dmg_pkg::DP_CARVE2: begin
          current_r <= nidx_r;
          visited_r <= visited_inc;
          if (done_new) begin
            done_r <= 1'b1;
            end_r  <= nidx_r;
          end
        end
        dmg_pkg::DP_POP_RD: begin
          stack_depth_r <= depth_dec;
        end
        dmg_pkg::DP_POP_LOAD: begin
          current_r <= sk_rdata;
        end
        default: ;
      endcase
    end
  end

  // probe and result payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      dmg_pkg::DP_START: begin
        dir_r <= dmg_pkg::dir_t'(2'(in_random_dir + 2'd1));
        try_r <= '0;
      end
      dmg_pkg::DP_LATCH: begin
        cur_links_r <= lk_rdata[LW-1:0];
      end
      dmg_pkg::DP_NB_READ: begin
        nidx_r <= nidx;
      end
      dmg_pkg::DP_NEXT_DIR: begin
        dir_r <= dmg_pkg::dir_t'(2'(dir_r + 2'd1));
        try_r <= try_r + dmg_pkg::TRY_W'(1);
      end
      dmg_pkg::DP_EMIT: begin
        out_kind_r <= cmd.kind;
        out_cell_r <= current_r;
        out_dir_r  <= (cmd.kind == dmg_pkg::KIND_ADVANCE) ? dir_r : dmg_pkg::DIR_N;
        out_fin_r  <= done_r;
        out_end_r  <= done_r ? end_r : '0;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {1'b0, out_end_r[CW-1:XW], out_end_r[XW-1:0], out_fin_r, out_dir_r,
                       out_cell_r[CW-1:XW], out_cell_r[XW-1:0]};

  `DMG_ASSERT_NOW(a_depth_below_count, 1'b1, stack_depth_r <= visited_r,
                  "stack deeper than the visited count")
  `DMG_ASSERT_NEXT(a_push_grows,
                   (cmd.op == dmg_pkg::DP_CARVE1) && (stack_depth_r < NW'(dmg_pkg::CELLS)),
                   stack_depth_r == $past(stack_depth_r) + NW'(1),
                   "push did not grow the stack")
  `DMG_ASSERT_NOW(a_end_zero_until_done, out_valid_r && !out_fin_r, out_end_r == '0,
                  "end cell shown before the maze is finished")

endmodule

>>> rtl/dfs_maze_generator.sv
// channel  dir  handshake                 payload
// in_      in   in_tvalid / in_tready     tuser: mode   tdata: random_dir
// out_     out  out_tvalid / out_tready   tuser: step_kind
//                                         tdata: cell_x cell_z opened_dir finished end_x end_z
// cfg_     in   cfg_we                    cfg_addr: register index, cfg_wdata: value
//
// A walk step runs LATCH, TRY, TEST, CARVE1, CARVE2 and EMIT if the first direction carves;
// up to five tries are probed, an in-bounds one via TRY and TEST, an off-grid one via TRY.
// A restart sweeps the 1024-entry link memory, one entry per cycle, before its result.
// After reset the same sweep runs before the first request is taken.
// The next request can be taken in the same cycle that out_tvalid rises.
// A stalled result sits in the output register; the next request is taken meanwhile.
module dfs_maze_generator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dmg_pkg::IN_DATA_W-1:0]      in_tdata,   // [1:0] random_dir
  input  logic                               in_tuser,   // [0] mode
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [4:0] cell_x, [9:5] cell_z, [11:10] opened_dir, [12] finished,
  // [17:13] end_x, [22:18] end_z
  output logic [dmg_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [1:0]                         out_tuser,  // [1:0] step_kind
  input  logic                               cfg_we,
  input  logic [dmg_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [dmg_pkg::CFG_W-1:0]          cfg_wdata
);

  dmg_pkg::dp_cmd_t    cmd;
  dmg_pkg::dp_status_t status;

  dmg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  dmg_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_random_dir (in_tdata[1:0]),
    .cmd           (cmd),
    .status        (status),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_tuser     (out_tuser),
    .out_tdata     (out_tdata)
  );

endmodule
